// ===== rtl/bac_pkg.sv =====
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types and constants of the binary arithmetic decoder core: stream
// field widths, item function codes and the sequencer state type.
// ----------------------------------------------------------------------------
package bac_pkg;

  // Fixed widths of the stream fields.
  localparam int WINDOW_W    = 32;
  localparam int FIELD_CNT_W = 16;
  localparam int USED_W      = 6;
  localparam int IN_TDATA_W  = 64;
  localparam int OUT_TDATA_W = 8;

  // Item function codes carried on the slave tuser bit.
  localparam logic FUNC_INIT   = 1'b0;
  localparam logic FUNC_DECODE = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL0,
    ST_MUL1,
    ST_CMP,
    ST_DIV,
    ST_UPD,
    ST_NORM,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/binary_arithmetic_decoder_core.sv =====
// Sequencing: an init beat goes from idle straight to the output load; a decode
// beat passes through the multiplier states MUL0 and MUL1, a compare, the divider,
// a bound update, renormalization (N steps, at most PRECISION) and the output
// load. A zero total count skips the divider. The core takes one beat at a time
// and accepts the next only back in idle. Reset (synchronous, active high)
// restores the bounds and tag and empties the output.
// ----------------------------------------------------------------------------
// binary_arithmetic_decoder_core
// Integer binary arithmetic decoder. One shared multiplier, a radix-2
// restoring divider and a one-bit-per-cycle renormalizer run under a small
// sequencer to decode one symbol per decode beat.
// ----------------------------------------------------------------------------
module binary_arithmetic_decoder_core #(
  parameter int PRECISION  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  // Slave stream.
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: code_window[31:0], count_one[47:32], total_count[63:48].
  input  logic [bac_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: func (0 = init, 1 = decode).
  input  logic                              s_axis_tuser,
  // Master stream.
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: decoded_bit[0], bits_used[6:1], interval_fault[7].
  output logic [bac_pkg::OUT_TDATA_W-1:0]   m_axis_tdata
);

  // Effective count width after masking to COUNT_BITS.
  localparam int CW  = (COUNT_BITS < bac_pkg::FIELD_CNT_W) ? COUNT_BITS
                                                          : bac_pkg::FIELD_CNT_W;
  localparam int RW  = PRECISION + 1;
  localparam int PW  = RW + CW;
  localparam int SW  = PRECISION + 2;
  localparam int DCW = $clog2(PRECISION + 2);
  localparam int UW  = bac_pkg::USED_W;

  bac_pkg::state_t state, state_next;

  logic [PRECISION-1:0]          low_b;
  logic [PRECISION-1:0]          high_b;
  logic [PRECISION-1:0]          tag;
  logic [bac_pkg::WINDOW_W-1:0]  window;
  logic [CW-1:0]                 tot;
  logic [CW-1:0]                 cum0;
  logic                          tot_zero;
  logic [RW-1:0]                 offs1;
  logic [RW-1:0]                 rng;
  logic [PW-1:0]                 a_prod;
  logic [CW-1:0]                 rem;
  logic [RW-1:0]                 dvd;
  logic [DCW-1:0]                div_cnt;
  logic                          sym;
  logic                          fault;
  logic [UW-1:0]                 used_cnt;
  logic                          out_valid;
  logic                          out_bit;
  logic [UW-1:0]                 out_used;
  logic                          out_fault;

  // Input field split.
  logic [bac_pkg::WINDOW_W-1:0]  in_window;
  logic [CW-1:0]                 in_c1;
  logic [CW-1:0]                 in_tot;
  logic                          in_accept;

  assign in_window = s_axis_tdata[31:0];
  assign in_c1     = s_axis_tdata[32 +: CW];
  assign in_tot    = s_axis_tdata[48 +: CW];
  assign in_accept = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state == bac_pkg::ST_IDLE);

  // Interval width and tag offset at acceptance, modulo 2^PRECISION.
  logic [PRECISION-1:0] span;
  logic [PRECISION-1:0] offset;
  assign span   = high_b - low_b;
  assign offset = tag - low_b;

  // Shared multiplier: (offset + 1) * total, then range * cum0.
  logic [RW-1:0] mul_a;
  logic [CW-1:0] mul_b;
  logic [PW-1:0] prod;
  assign mul_a = (state == bac_pkg::ST_MUL0) ? offs1 : rng;
  assign mul_b = (state == bac_pkg::ST_MUL0) ? tot : cum0;
  assign prod  = {{CW{1'b0}}, mul_a} * {{RW{1'b0}}, mul_b};

  // Restoring divider step: one quotient bit per cycle.
  logic [CW:0]   div_try;
  logic [CW+1:0] div_sub;
  logic          div_q;
  assign div_try = {rem, dvd[RW-1]};
  assign div_sub = {1'b0, div_try} - {2'b00, tot};
  assign div_q   = !div_sub[CW+1];

  // Bound update after the symbol decision.
  logic [SW-1:0] lo_ext;
  logic [SW-1:0] add_lo;
  logic [SW-1:0] add_hi;
  logic [SW-1:0] new_lo;
  logic [SW-1:0] hi_sum;
  logic [SW-1:0] hi_sum_m1;
  logic          upd_fault;
  assign lo_ext    = {2'b00, low_b};
  assign add_lo    = (sym && !tot_zero) ? {1'b0, dvd} : '0;
  assign add_hi    = tot_zero ? '0 : (sym ? {1'b0, rng} : {1'b0, dvd});
  assign new_lo    = lo_ext + add_lo;
  assign hi_sum    = lo_ext + add_hi;
  assign hi_sum_m1 = hi_sum - SW'(1);
  assign upd_fault = (hi_sum <= new_lo + SW'(1));

  // Renormalization step decision.
  logic shift_step;
  logic under_step;
  logic norm_go;
  assign shift_step = !(high_b[PRECISION-1] ^ low_b[PRECISION-1]);
  assign under_step = !high_b[PRECISION-2] && low_b[PRECISION-2];
  assign norm_go    = (shift_step || under_step) && (used_cnt < UW'(PRECISION));

  // Output register loads when empty or being drained.
  logic out_load;
  assign out_load = (state == bac_pkg::ST_DONE) && (!out_valid || m_axis_tready);

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bac_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic of the sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      bac_pkg::ST_IDLE: begin
        if (in_accept) begin
          state_next = (s_axis_tuser == bac_pkg::FUNC_INIT) ? bac_pkg::ST_DONE
                                                            : bac_pkg::ST_MUL0;
        end
      end
      bac_pkg::ST_MUL0: state_next = bac_pkg::ST_MUL1;
      bac_pkg::ST_MUL1: state_next = bac_pkg::ST_CMP;
      bac_pkg::ST_CMP: begin
        state_next = tot_zero ? bac_pkg::ST_UPD : bac_pkg::ST_DIV;
      end
      bac_pkg::ST_DIV: begin
        if (div_cnt == DCW'(PRECISION)) begin
          state_next = bac_pkg::ST_UPD;
        end
      end
      bac_pkg::ST_UPD: state_next = bac_pkg::ST_NORM;
      bac_pkg::ST_NORM: begin
        if (!norm_go) begin
          state_next = bac_pkg::ST_DONE;
        end
      end
      bac_pkg::ST_DONE: begin
        if (out_load) begin
          state_next = bac_pkg::ST_IDLE;
        end
      end
    endcase
  end

  // Coder state: bounds and tag; reset sets the full interval and a zero tag.
  always_ff @(posedge clk) begin
    if (rst) begin
      low_b  <= '0;
      high_b <= '1;
      tag    <= '0;
    end else begin
      priority case (1'b1)
        in_accept && (s_axis_tuser == bac_pkg::FUNC_INIT): begin
          low_b  <= '0;
          high_b <= '1;
          tag    <= in_window[bac_pkg::WINDOW_W-1 -: PRECISION];
        end
        state == bac_pkg::ST_UPD: begin
          low_b  <= new_lo[PRECISION-1:0];
          high_b <= hi_sum_m1[PRECISION-1:0];
        end
        (state == bac_pkg::ST_NORM) && norm_go: begin
          // Shift in the next code bit; an underflow step flips the MSBs.
          low_b  <= {low_b[PRECISION-2:0], 1'b0}  ^ {!shift_step, {(PRECISION-1){1'b0}}};
          high_b <= {high_b[PRECISION-2:0], 1'b1} ^ {!shift_step, {(PRECISION-1){1'b0}}};
          tag    <= {tag[PRECISION-2:0], window[bac_pkg::WINDOW_W-1]}
                    ^ {!shift_step, {(PRECISION-1){1'b0}}};
        end
        default: begin
        end
      endcase
    end
  end

  // Working registers of the datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      bac_pkg::ST_IDLE: begin
        window   <= in_window;
        tot      <= in_tot;
        cum0     <= (in_c1 > in_tot) ? '0 : in_tot - in_c1;
        tot_zero <= (in_tot == '0);
        offs1    <= {1'b0, offset} + RW'(1);
        rng      <= {1'b0, span} + RW'(1);
        sym      <= 1'b0;
        fault    <= 1'b0;
        used_cnt <= (s_axis_tuser == bac_pkg::FUNC_INIT) ? UW'(PRECISION) : '0;
      end
      bac_pkg::ST_MUL0: begin
        a_prod <= prod;
      end
      bac_pkg::ST_MUL1: begin
        rem <= prod[PW-1:RW];
        dvd <= prod[RW-1:0];
      end
      bac_pkg::ST_CMP: begin
        // Symbol 0 when the total is nonzero and (offset+1)*total <= cum0*range.
        sym     <= tot_zero || (a_prod > {rem, dvd});
        div_cnt <= '0;
      end
      bac_pkg::ST_DIV: begin
        rem     <= div_q ? div_sub[CW-1:0] : div_try[CW-1:0];
        dvd     <= {dvd[RW-2:0], div_q};
        div_cnt <= div_cnt + DCW'(1);
      end
      bac_pkg::ST_UPD: begin
        fault <= upd_fault;
      end
      bac_pkg::ST_NORM: begin
        if (norm_go) begin
          window   <= {window[bac_pkg::WINDOW_W-2:0], 1'b0};
          used_cnt <= used_cnt + UW'(1);
        end
      end
      bac_pkg::ST_DONE: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_bit   <= sym;
      out_used  <= used_cnt;
      out_fault <= fault;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_fault, out_used, out_bit};

`ifndef SYNTHESIS
  // Renormalization never takes more code bits than the precision.
  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_cnt <= UW'(PRECISION))
    else $error("bits used exceeds precision");

  // Divider remainder stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (state == bac_pkg::ST_DIV) |-> (rem < tot))
    else $error("divider remainder out of range");

  // An accepted init beat goes straight to result delivery.
  a_init_path: assert property (@(posedge clk) disable iff (rst)
    (in_accept && (s_axis_tuser == bac_pkg::FUNC_INIT)) |=> (state == bac_pkg::ST_DONE))
    else $error("init beat did not go to result delivery");

  // The divider runs only after the compare with a nonzero total.
  a_div_entry: assert property (@(posedge clk) disable iff (rst)
    $rose(state == bac_pkg::ST_DIV) |-> ($past(state) == bac_pkg::ST_CMP) && !tot_zero)
    else $error("divider entered unexpectedly");

  // A result load leaves the output valid and the sequencer back in idle.
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == bac_pkg::ST_IDLE))
    else $error("result load lost");
`endif

endmodule
